// File: rtl/ohlcv_pkg.sv
// Shared widths, payload types and queue sizing for the candle aggregator.
package ohlcv_pkg;

  localparam int TIME_W  = 40;
  localparam int PRICE_W = 48;
  localparam int QTY_W   = 48;
  localparam int VOL_W   = 64;
  localparam int CNT_W   = 32;
  localparam int INTV_W  = 17;

  localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(60);

  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = TIME_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [TIME_W-1:0]  trade_time;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]   quote_quantity;
    logic               is_sell;
  } trade_t;

  typedef struct packed {
    logic [TIME_W-1:0]  open_time;
    logic [TIME_W-1:0]  close_time;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [VOL_W-1:0]   buy_volume;
    logic [VOL_W-1:0]   sell_volume;
    logic [CNT_W-1:0]   buy_count;
    logic [CNT_W-1:0]   sell_count;
  } candle_t;

  typedef struct packed {
    trade_t             trade;
    logic [TIME_W-1:0]  bucket_end;
    logic [INTV_W-1:0]  interval;
  } job_t;

endpackage

// File: rtl/ohlcv_front.sv
// Front end: accepts a request and computes its bucket end with a radix-4 remainder unit.
module ohlcv_front
  import ohlcv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  trade_t            in_trade,
  input  logic [INTV_W-1:0] interval,
  output logic              push_valid,
  input  logic              push_ready,
  output job_t              push_job
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  trade_t            trade_r;
  logic [TIME_W-1:0] tsh_r, tsh_nxt;
  logic [INTV_W-1:0] rem_r, rem_nxt;
  logic [INTV_W-1:0] iv_r;
  logic [STEP_W-1:0] step_r;
  logic [INTV_W:0]   trial;
  logic [TIME_W:0]   end_sum;
  logic [INTV_W-1:0] iv_gap;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    rem_nxt = rem_r;
    tsh_nxt = tsh_r;
    trial   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial   = {rem_nxt, tsh_nxt[TIME_W-1]};
      tsh_nxt = {tsh_nxt[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, iv_r}) begin
        trial = trial - {1'b0, iv_r};
      end
      rem_nxt = trial[INTV_W-1:0];
    end
  end

  assign iv_gap  = iv_r - rem_r;
  assign end_sum = {1'b0, trade_r.trade_time} + (TIME_W + 1)'(iv_gap);

  assign push_valid          = (state_r == S_PUSH);
  assign push_job.trade      = trade_r;
  assign push_job.bucket_end = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];
  assign push_job.interval   = iv_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      trade_r <= in_trade;
      tsh_r   <= in_trade.trade_time;
      rem_r   <= '0;
      step_r  <= '0;
      iv_r    <= (interval == '0) ? INTV_W'(1) : interval;
    end else if (state_r == S_DIV) begin
      tsh_r  <= tsh_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + STEP_W'(1);
    end
  end

endmodule

// File: rtl/ohlcv_queue.sv
// Short request queue between the front end and the candle update stage.
module ohlcv_queue
  import ohlcv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/ohlcv_back.sv
// Back end: applies each request to the open candle and registers finished candles.
module ohlcv_back
  import ohlcv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  job_t    pop_job,
  output logic    out_valid,
  input  logic    out_ready,
  output candle_t out_candle
);

  logic               started_r;
  logic [TIME_W-1:0]  start_r, end_r;
  logic [PRICE_W-1:0] first_r, max_r, min_r, last_r;
  logic [VOL_W-1:0]   buy_sum_r, sell_sum_r;
  logic [CNT_W-1:0]   buy_cnt_r, sell_cnt_r;
  logic               out_valid_r;
  candle_t            out_r;

  logic               emit, opening, fire;
  trade_t             tr;
  logic [VOL_W:0]     buy_add, sell_add;
  logic [VOL_W-1:0]   qty_ext;

  assign tr        = pop_job.trade;
  assign emit      = started_r && (tr.trade_time > end_r);
  assign opening   = !started_r || emit;
  assign pop_ready = !emit || !out_valid_r || out_ready;
  assign fire      = pop_valid && pop_ready;

  assign qty_ext  = VOL_W'(tr.quote_quantity);
  assign buy_add  = {1'b0, buy_sum_r} + {1'b0, qty_ext};
  assign sell_add = {1'b0, sell_sum_r} + {1'b0, qty_ext};

  assign out_valid  = out_valid_r;
  assign out_candle = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        started_r <= 1'b1;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_r.open_time   <= start_r;
      out_r.close_time  <= end_r;
      out_r.open_price  <= first_r;
      out_r.high_price  <= max_r;
      out_r.low_price   <= min_r;
      out_r.close_price <= last_r;
      out_r.buy_volume  <= buy_sum_r;
      out_r.sell_volume <= sell_sum_r;
      out_r.buy_count   <= buy_cnt_r;
      out_r.sell_count  <= sell_cnt_r;
    end
    if (fire) begin
      last_r <= tr.trade_price;
      if (opening) begin
        start_r    <= emit ? end_r : pop_job.bucket_end - TIME_W'(pop_job.interval);
        end_r      <= pop_job.bucket_end;
        first_r    <= tr.trade_price;
        max_r      <= tr.trade_price;
        min_r      <= tr.trade_price;
        buy_sum_r  <= tr.is_sell ? '0 : qty_ext;
        sell_sum_r <= tr.is_sell ? qty_ext : '0;
        buy_cnt_r  <= tr.is_sell ? '0 : CNT_W'(1);
        sell_cnt_r <= tr.is_sell ? CNT_W'(1) : '0;
      end else begin
        if (tr.trade_price > max_r) begin
          max_r <= tr.trade_price;
        end
        if (tr.trade_price < min_r) begin
          min_r <= tr.trade_price;
        end
        if (tr.is_sell) begin
          sell_sum_r <= sell_add[VOL_W] ? {VOL_W{1'b1}} : sell_add[VOL_W-1:0];
          if (sell_cnt_r != {CNT_W{1'b1}}) begin
            sell_cnt_r <= sell_cnt_r + CNT_W'(1);
          end
        end else begin
          buy_sum_r <= buy_add[VOL_W] ? {VOL_W{1'b1}} : buy_add[VOL_W-1:0];
          if (buy_cnt_r != {CNT_W{1'b1}}) begin
            buy_cnt_r <= buy_cnt_r + CNT_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: rtl/trade_ohlcv_candle_aggregator_unit.sv
// Top level of the trade OHLCV candle aggregator.
// In the front end each trade request is accepted, the radix-4 remainder unit reduces
// the 40-bit trade time by the interval, and the bucket end is formed and pushed into
// a two-entry queue. The update stage holds a finished candle in an output register
// and drains the queue at one request per cycle unless a closing trade finds it full,
// so a stalled result side backs up through the queue before the input stalls. Candles
// are emitted only when a later trade closes them; the candle open at the end is kept.
// The interval register resets to 60 and is written through the cfg port.
module trade_ohlcv_candle_aggregator_unit
  import ohlcv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  trade_t            in_trade,
  output logic              out_valid,
  input  logic              out_ready,
  output candle_t           out_candle,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [INTV_W-1:0] cfg_interval_seconds
);

  logic [INTV_W-1:0] interval_r;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  job_t              push_job, pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTV_RESET;
    end else if (cfg_valid) begin
      interval_r <= cfg_interval_seconds;
    end
  end

  ohlcv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_trade   (in_trade),
    .interval   (interval_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  ohlcv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  ohlcv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_candle (out_candle)
  );

endmodule

// File: tb/candle_checker.sv
// Candle checker: predicts the candles closed by accepted trades and compares each result.
module candle_checker
  import ohlcv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  trade_t            in_trade,
  input  logic              out_valid,
  input  logic              out_ready,
  input  candle_t           out_candle,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [INTV_W-1:0] cfg_interval_seconds,
  output int                mismatch_count,
  output int                candles_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [INTV_W-1:0]  interval_reg;
  logic               candle_open;
  logic [TIME_W-1:0]  start_time;
  logic [TIME_W-1:0]  end_time;
  logic [PRICE_W-1:0] first_px;
  logic [PRICE_W-1:0] max_px;
  logic [PRICE_W-1:0] min_px;
  logic [PRICE_W-1:0] last_px;
  logic [VOL_W-1:0]   buy_vol;
  logic [VOL_W-1:0]   sell_amount;
  logic [CNT_W-1:0]   buy_tally;
  logic [CNT_W-1:0]   sell_tally;
  candle_t            expected_candles[$];
  int                 fails;

  function automatic logic [TIME_W-1:0] bucket_end_of(logic [TIME_W-1:0] t,
                                                      logic [INTV_W-1:0] iv);
    logic [63:0] e;
    e = 64'(t) - (64'(t) % 64'(iv)) + 64'(iv);
    if ((e >> TIME_W) != 0) return '1;
    return e[TIME_W-1:0];
  endfunction

  function automatic logic [VOL_W-1:0] sat_sum(logic [VOL_W-1:0] a, logic [QTY_W-1:0] b);
    logic [VOL_W:0] s;
    s = {1'b0, a} + (VOL_W+1)'(b);
    return s[VOL_W] ? '1 : s[VOL_W-1:0];
  endfunction

  function automatic void take_trade(trade_t tr);
    logic [INTV_W-1:0] iv;
    logic              fresh;
    candle_t           c;
    iv = (interval_reg == 0) ? INTV_W'(1) : interval_reg;
    fresh = 1'b0;
    if (!candle_open) begin
      end_time = bucket_end_of(tr.trade_time, iv);
      start_time = end_time - TIME_W'(iv);
      candle_open = 1'b1;
      fresh = 1'b1;
    end else if (tr.trade_time > end_time) begin
      c.open_time   = start_time;
      c.close_time  = end_time;
      c.open_price  = first_px;
      c.high_price  = max_px;
      c.low_price   = min_px;
      c.close_price = last_px;
      c.buy_volume  = buy_vol;
      c.sell_volume = sell_amount;
      c.buy_count   = buy_tally;
      c.sell_count  = sell_tally;
      expected_candles.push_back(c);
      start_time = end_time;
      end_time = bucket_end_of(tr.trade_time, iv);
      fresh = 1'b1;
    end
    if (fresh) begin
      first_px = tr.trade_price;
      max_px = tr.trade_price;
      min_px = tr.trade_price;
      buy_vol = '0;
      sell_amount = '0;
      buy_tally = '0;
      sell_tally = '0;
    end
    if (tr.trade_price > max_px) max_px = tr.trade_price;
    if (tr.trade_price < min_px) min_px = tr.trade_price;
    last_px = tr.trade_price;
    if (tr.is_sell) begin
      sell_amount = sat_sum(sell_amount, tr.quote_quantity);
      if (sell_tally != '1) sell_tally = sell_tally + 1'b1;
    end else begin
      buy_vol = sat_sum(buy_vol, tr.quote_quantity);
      if (buy_tally != '1) buy_tally = buy_tally + 1'b1;
    end
  endfunction

  task automatic compare_field(input string field, input logic [VOL_W-1:0] want,
                               input logic [VOL_W-1:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= 10) $display("candle field %s: expected %0h, got %0h", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    candle_t c;
    if (!rst_n) begin
      interval_reg = INTV_RESET;
      candle_open = 1'b0;
      start_time = '0;
      end_time = '0;
      first_px = '0;
      max_px = '0;
      min_px = '0;
      last_px = '0;
      buy_vol = '0;
      sell_amount = '0;
      buy_tally = '0;
      sell_tally = '0;
      expected_candles.delete();
    end else begin
      if (cfg_valid && cfg_ready) interval_reg = cfg_interval_seconds;
      if (in_valid && in_ready) take_trade(in_trade);
      if (out_valid && out_ready) begin
        if (expected_candles.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected candle: open_time %0h close_time %0h",
                     out_candle.open_time, out_candle.close_time);
          end
        end else begin
          c = expected_candles.pop_front();
          compare_field("open_time", c.open_time, out_candle.open_time);
          compare_field("close_time", c.close_time, out_candle.close_time);
          compare_field("open_price", c.open_price, out_candle.open_price);
          compare_field("high_price", c.high_price, out_candle.high_price);
          compare_field("low_price", c.low_price, out_candle.low_price);
          compare_field("close_price", c.close_price, out_candle.close_price);
          compare_field("buy_volume", c.buy_volume, out_candle.buy_volume);
          compare_field("sell_volume", c.sell_volume, out_candle.sell_volume);
          compare_field("buy_count", c.buy_count, out_candle.buy_count);
          compare_field("sell_count", c.sell_count, out_candle.sell_count);
        end
      end
    end
    mismatch_count <= fails;
    candles_due <= expected_candles.size();
  end

endmodule

// File: tb/testbench.sv
// Testbench top: clock, reset, trade and interval stimulus, result stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ohlcv_pkg::*;

  localparam int DRAIN_CYCLES   = 48;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 50;
  localparam int PRESSURE_PHASE = 2;
  localparam int HIGH_PHASE     = 4;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [QTY_W-1:0]   QTY_MAX   = '1;
  localparam logic [INTV_W-1:0]  INTV_MAX  = '1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  trade_t            in_trade;
  logic              out_valid;
  logic              out_ready;
  candle_t           out_candle;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [INTV_W-1:0] cfg_interval_seconds;
  int                mismatch_count;
  int                candles_due;
  int                cycles;
  bit                tx_idle;
  bit                rx_idle;
  bit                hold_pending;

  trade_ohlcv_candle_aggregator_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_trade             (in_trade),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_candle           (out_candle),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_interval_seconds (cfg_interval_seconds)
  );

  candle_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_trade             (in_trade),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_candle           (out_candle),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_interval_seconds (cfg_interval_seconds),
    .mismatch_count       (mismatch_count),
    .candles_due          (candles_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_trade(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] px,
                            input logic [QTY_W-1:0] qty, input logic sell);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_trade <= '{trade_time: t, trade_price: px, quote_quantity: qty, is_sell: sell};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (candles_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTV_W-1:0] iv);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_interval_seconds <= iv;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = rx_idle ? $urandom_range(0, 15) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int                 phase_iv[PHASES];
    logic [INTV_W-1:0]  iv;
    logic [63:0]        span;
    logic [63:0]        r;
    logic [63:0]        t64;
    logic [TIME_W-1:0]  cur_time;
    logic [PRICE_W-1:0] px;
    logic [QTY_W-1:0]   qty;
    int                 pick;
    phase_iv = '{60, 7, 1, 3600, 86400, 131071, 0, 2, 60};
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_trade = '0;
    cfg_valid = 1'b0;
    cfg_interval_seconds = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_pending = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset interval: first trade, trade on the bucket end, late trade, gap.
    send_trade(0, 0, 0, 1'b0);
    send_trade(60, PRICE_MAX, QTY_MAX, 1'b1);
    send_trade(30, 5, 1, 1'b0);
    send_trade(61, 100, 1, 1'b0);
    send_trade(10, 7, 3, 1'b1);
    send_trade(1000, 50, 9, 1'b1);
    send_trade(1020, PRICE_MAX, QTY_MAX, 1'b0);
    send_trade(1021, 1, 2, 1'b0);
    settle();
    write_interval('0);
    send_trade(2000, PRICE_MAX, 4, 1'b1);
    send_trade(2000, 0, QTY_MAX, 1'b0);
    send_trade(2001, 9, 5, 1'b1);
    send_trade(2003, 3, 6, 1'b0);
    settle();
    write_interval(INTV_MAX);
    send_trade(300000, 11, 7, 1'b0);
    send_trade(400000, 12, 8, 1'b1);
    settle();
    write_interval(86400);
    send_trade(500000, 13, 9, 1'b0);
    send_trade(600000, 14, 10, 1'b1);
    cur_time = 600000;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      iv = (ph == PHASES - 1) ? INTV_W'($urandom_range(1, 131071)) : INTV_W'(phase_iv[ph]);
      write_interval(iv);
      span = (iv == 0) ? 64'd1 : 64'(iv);
      tx_idle = (ph % 3 != 1);
      rx_idle = (ph % 4 != 2);
      if (ph == PRESSURE_PHASE) begin
        tx_idle = 1'b0;
        hold_pending = 1'b1;
      end
      if (ph == HIGH_PHASE) cur_time = cur_time | (TIME_W'(1) << (TIME_W - 1));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        r = {$urandom, $urandom};
        if (ph == PRESSURE_PHASE) t64 = 64'(cur_time) + $urandom_range(1, 3);
        else if (pick < 10) t64 = r % (64'(cur_time) + 1);
        else if (pick < 15) t64 = 64'(cur_time);
        else if (pick < 22) t64 = 64'(cur_time) + (r % (span * 50));
        else t64 = 64'(cur_time) + (r % (span * 2 + 1));
        if (t64[TIME_W-1:0] > cur_time) cur_time = t64[TIME_W-1:0];
        r = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        px = (pick == 0) ? '0 : (pick == 1) ? PRICE_MAX : r[PRICE_W-1:0];
        r = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        qty = (pick == 0) ? '0 : (pick == 1) ? QTY_MAX : r[QTY_W-1:0];
        send_trade(t64[TIME_W-1:0], px, qty, 1'($urandom_range(0, 1)));
      end
    end

    // Push the bucket end past the top of the time range.
    settle();
    write_interval(86400);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_trade(TIME_MAX - 5, 21, 22, 1'b0);
    send_trade(TIME_MAX, PRICE_MAX, QTY_MAX, 1'b1);
    send_trade(TIME_MAX, 0, 1, 1'b0);
    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ohlcv_pkg.sv
rtl/ohlcv_front.sv
rtl/ohlcv_queue.sv
rtl/ohlcv_back.sv
rtl/trade_ohlcv_candle_aggregator_unit.sv
tb/candle_checker.sv
tb/testbench.sv
